@@ hdl/assert_macros.svh @@
// ============================================================================
// assert_macros.svh
// Concurrent assertion helpers used by e2c_pipe_ctrl; empty under synthesis.
// ============================================================================
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define E2C_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error("assertion failed");
`define E2C_ASSERT_NEVER(lbl, clk, rstn, cond) \
    `E2C_ASSERT(lbl, clk, rstn, !(cond))
`else
`define E2C_ASSERT(lbl, clk, rstn, prop)
`define E2C_ASSERT_NEVER(lbl, clk, rstn, cond)
`endif

`endif

@@ hdl/e2c_pkg.sv @@
// ============================================================================
// e2c_pkg
// Types, division constants and calendar tables for the epoch converter.
// ============================================================================
package e2c_pkg;

    localparam int unsigned NUM_STAGES = 9;

    typedef logic [31:0] t_epoch;
    typedef logic [11:0] t_year;
    typedef logic [3:0]  t_month;
    typedef logic [4:0]  t_mday;
    typedef logic [4:0]  t_hour;
    typedef logic [5:0]  t_minsec;
    typedef logic [2:0]  t_wday;

    typedef struct packed {
        logic [NUM_STAGES-1:0] en;   // stage loads this cycle
        logic [NUM_STAGES-1:0] vld;  // stage holds an item
    } t_pipe_ctl;

    // Reciprocals floor(2^32 / d); quotient estimate is q or q-1.
    localparam logic [22:0] K_DAY   = 23'd6362914;    // 86400 / 128 = 675
    localparam logic [9:0]  DAY_DIV = 10'd675;
    localparam logic [21:0] K_CYC   = 22'd2939744;    // 1461-day cycle
    localparam logic [10:0] CYC_DAYS = 11'd1461;
    localparam logic [29:0] K_WEEK  = 30'd613566756;  // 7
    localparam logic [2:0]  WEEK_DAYS = 3'd7;
    localparam logic [24:0] K_HOUR  = 25'd19088743;   // 3600 / 16 = 225
    localparam logic [7:0]  HOUR_DIV = 8'd225;
    localparam logic [26:0] K_MIN   = 27'd71582788;   // 60
    localparam logic [5:0]  MIN_DIV = 6'd60;

    // Day numbering restarts at 1968-03-01 so the leap day ends each year.
    localparam logic [15:0] MAR_OFS      = 16'd671;
    // 2100-03-01: from here on skip the missing leap day of 2100.
    localparam logic [15:0] CENT_SKIP    = 16'd47541;
    localparam logic [11:0] BASE_YEAR    = 12'd1968;
    localparam logic [15:0] WDAY_OFS     = 16'd3;
    localparam logic [3:0]  FIRST_JAN_MP = 4'd10;

    function automatic logic [10:0] year_base(input logic [1:0] yc);
        logic [10:0] v;
        unique case (yc)
            2'd0:    v = 11'd0;
            2'd1:    v = 11'd365;
            2'd2:    v = 11'd730;
            default: v = 11'd1095;
        endcase
        return v;
    endfunction

    // First day of each month counted from March 1.
    function automatic logic [8:0] month_start(input logic [3:0] mp);
        logic [8:0] v;
        unique case (mp)
            4'd0:    v = 9'd0;
            4'd1:    v = 9'd31;
            4'd2:    v = 9'd61;
            4'd3:    v = 9'd92;
            4'd4:    v = 9'd122;
            4'd5:    v = 9'd153;
            4'd6:    v = 9'd184;
            4'd7:    v = 9'd214;
            4'd8:    v = 9'd245;
            4'd9:    v = 9'd275;
            4'd10:   v = 9'd306;
            4'd11:   v = 9'd337;
            default: v = 9'd0;
        endcase
        return v;
    endfunction

endpackage

@@ hdl/e2c_ifs.sv @@
// ============================================================================
// e2c_ifs
// Valid/ready channels for timestamps in and calendar records out.
// ============================================================================
interface e2c_in_if;
    import e2c_pkg::*;
    logic   valid;
    logic   ready;
    t_epoch epoch_seconds;
    modport source (output valid, output epoch_seconds, input ready);
    modport sink   (input valid, input epoch_seconds, output ready);
endinterface

interface e2c_out_if;
    import e2c_pkg::*;
    logic    valid;
    logic    ready;
    t_year   year;
    t_month  month;
    t_mday   day_of_month;
    t_hour   hour;
    t_minsec minute;
    t_minsec second;
    t_wday   weekday;
    modport source (output valid, output year, output month, output day_of_month,
                    output hour, output minute, output second, output weekday,
                    input ready);
    modport sink   (input valid, input year, input month, input day_of_month,
                    input hour, input minute, input second, input weekday,
                    output ready);
endinterface

@@ hdl/e2c_pipe_ctrl.sv @@
// ============================================================================
// e2c_pipe_ctrl
// Valid bits and per-stage load enables; bubbles collapse under a stall.
// ============================================================================
`include "assert_macros.svh"

module e2c_pipe_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_out_ready,
    output logic              o_in_ready,
    output e2c_pkg::t_pipe_ctl o_ctl
);
    import e2c_pkg::*;

    logic [NUM_STAGES-1:0] r_vld;
    logic [NUM_STAGES-1:0] n_en;
    logic                  acc_in;
    logic                  acc_out;

    // A stage may load when empty or when the stage after it loads.
    always_comb begin
        n_en[NUM_STAGES-1] = !r_vld[NUM_STAGES-1] || i_out_ready;
        for (int i = NUM_STAGES - 2; i >= 0; i--) begin
            n_en[i] = !r_vld[i] || n_en[i+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (n_en[0]) begin
                r_vld[0] <= i_in_valid;
            end
            for (int i = 1; i < NUM_STAGES; i++) begin
                if (n_en[i]) begin
                    r_vld[i] <= r_vld[i-1];
                end
            end
        end
    end

    assign o_in_ready = n_en[0];
    assign o_ctl.en   = n_en;
    assign o_ctl.vld  = r_vld;
    assign acc_in     = i_in_valid && n_en[0];
    assign acc_out    = r_vld[NUM_STAGES-1] && i_out_ready;

    `E2C_ASSERT(a_ready_low_only_full, i_clk, i_rst_n, !o_in_ready |-> (r_vld[NUM_STAGES-1] && !i_out_ready))
    `E2C_ASSERT(a_accept_lands, i_clk, i_rst_n, acc_in |=> r_vld[0])
    `E2C_ASSERT(a_item_count, i_clk, i_rst_n, 1'b1 |=> ($countones(r_vld) == $past($countones(r_vld)) + $past(acc_in) - $past(acc_out)))

endmodule

@@ hdl/epoch_seconds_to_calendar.sv @@
// ============================================================================
// epoch_seconds_to_calendar
// Unix seconds to Gregorian date, time of day and ISO weekday.
// ============================================================================
// Usage:
//   i_in carries epoch_seconds (unsigned seconds since 1970-01-01 00:00:00);
//   o_out carries year, month, day_of_month, hour, minute, second and weekday
//   (1 = Monday .. 7 = Sunday). Each channel moves one item per transfer when
//   valid and ready are both high.
//   One item is taken every cycle unless all stages are full and stalled. The
//   nine register stages each hold about one constant multiply or one
//   subtract-and-correct step: seconds to days, days to 4-year cycles,
//   cycle to year and month, time of day to hour and minute.
//   Reset clears the stage valid bits only; no item is held afterwards.
//   When the receiver holds ready low, the result stays on o_out and empty
//   stages behind it keep filling; i_in.ready drops once every stage is full
//   and rises the cycle the result is taken.
// ============================================================================
module epoch_seconds_to_calendar (
    input  logic             i_clk,
    input  logic             i_rst_n,
    e2c_in_if.sink           i_in,
    e2c_out_if.source        o_out
);
    import e2c_pkg::*;

    t_pipe_ctl ctl;
    logic      in_ready;

    e2c_pipe_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_out_ready (o_out.ready),
        .o_in_ready  (in_ready),
        .o_ctl       (ctl)
    );

    assign i_in.ready = in_ready;

    // ---- stage 1: estimate (secs / 128) / 675 ------------------------------
    logic [24:0] r1_x;
    logic [6:0]  r1_lo;
    logic [47:0] r1_p;

    always_ff @(posedge i_clk) begin
        if (ctl.en[0]) begin
            r1_x  <= i_in.epoch_seconds[31:7];
            r1_lo <= i_in.epoch_seconds[6:0];
            r1_p  <= 48'(i_in.epoch_seconds[31:7]) * 48'(K_DAY);
        end
    end

    // ---- stage 2: back-multiply the day estimate ---------------------------
    logic [24:0] r2_x;
    logic [6:0]  r2_lo;
    logic [15:0] r2_q;
    logic [25:0] r2_m;

    always_ff @(posedge i_clk) begin
        if (ctl.en[1]) begin
            r2_x  <= r1_x;
            r2_lo <= r1_lo;
            r2_q  <= r1_p[47:32];
            r2_m  <= 26'(r1_p[47:32]) * 26'(DAY_DIV);
        end
    end

    // ---- stage 3: correct day count, rebuild time of day -------------------
    logic [24:0] s3_diff;
    logic [10:0] s3_r;
    logic [15:0] n3_days;
    logic [9:0]  n3_rd;
    logic [15:0] r3_days;
    logic [16:0] r3_tod;

    always_comb begin
        s3_diff = r2_x - r2_m[24:0];
        s3_r    = s3_diff[10:0];
        if (s3_r >= 11'(DAY_DIV)) begin
            n3_days = r2_q + 16'd1;
            n3_rd   = 10'(s3_r - 11'(DAY_DIV));
        end else begin
            n3_days = r2_q;
            n3_rd   = s3_r[9:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctl.en[2]) begin
            r3_days <= n3_days;
            r3_tod  <= {n3_rd, r2_lo};
        end
    end

    // ---- stage 4: cycle, weekday and hour estimates ------------------------
    logic [15:0] n4_e;
    logic [15:0] n4_wv;
    logic [15:0] r4_e;
    logic [15:0] r4_wv;
    logic [12:0] r4_th;
    logic [3:0]  r4_tlo;
    logic [37:0] r4_pe;
    logic [45:0] r4_pw;
    logic [37:0] r4_ph;

    always_comb begin
        n4_e  = (r3_days >= CENT_SKIP) ? r3_days + MAR_OFS + 16'd1 : r3_days + MAR_OFS;
        n4_wv = r3_days + WDAY_OFS;
    end

    always_ff @(posedge i_clk) begin
        if (ctl.en[3]) begin
            r4_e   <= n4_e;
            r4_wv  <= n4_wv;
            r4_th  <= r3_tod[16:4];
            r4_tlo <= r3_tod[3:0];
            r4_pe  <= 38'(n4_e) * 38'(K_CYC);
            r4_pw  <= 46'(n4_wv) * 46'(K_WEEK);
            r4_ph  <= 38'(r3_tod[16:4]) * 38'(K_HOUR);
        end
    end

    // ---- stage 5: back-multiply the three estimates ------------------------
    logic [15:0] r5_e;
    logic [5:0]  r5_c0;
    logic [16:0] r5_me;
    logic [15:0] r5_wv;
    logic [13:0] r5_w0;
    logic [16:0] r5_mw;
    logic [12:0] r5_th;
    logic [5:0]  r5_h0;
    logic [13:0] r5_mh;
    logic [3:0]  r5_tlo;

    always_ff @(posedge i_clk) begin
        if (ctl.en[4]) begin
            r5_e   <= r4_e;
            r5_c0  <= r4_pe[37:32];
            r5_me  <= 17'(r4_pe[37:32]) * 17'(CYC_DAYS);
            r5_wv  <= r4_wv;
            r5_w0  <= r4_pw[45:32];
            r5_mw  <= 17'(r4_pw[45:32]) * 17'(WEEK_DAYS);
            r5_th  <= r4_th;
            r5_h0  <= r4_ph[37:32];
            r5_mh  <= 14'(r4_ph[37:32]) * 14'(HOUR_DIV);
            r5_tlo <= r4_tlo;
        end
    end

    // ---- stage 6: correct cycle, weekday and hour --------------------------
    logic [15:0] s6_cd;
    logic [11:0] s6_cr;
    logic [15:0] s6_wd;
    logic [3:0]  s6_wr;
    logic [12:0] s6_hd;
    logic [8:0]  s6_hr;
    logic [5:0]  n6_c;
    logic [10:0] n6_rc;
    logic [2:0]  n6_widx;
    logic [5:0]  n6_hour;
    logic [7:0]  n6_rt;
    logic [5:0]  r6_c;
    logic [10:0] r6_rc;
    t_wday       r6_wd;
    t_hour       r6_hr;
    logic [11:0] r6_rem;

    always_comb begin
        s6_cd = r5_e - r5_me[15:0];
        s6_cr = s6_cd[11:0];
        if (s6_cr >= 12'(CYC_DAYS)) begin
            n6_c  = r5_c0 + 6'd1;
            n6_rc = 11'(s6_cr - 12'(CYC_DAYS));
        end else begin
            n6_c  = r5_c0;
            n6_rc = s6_cr[10:0];
        end

        s6_wd = r5_wv - r5_mw[15:0];
        s6_wr = s6_wd[3:0];
        if (s6_wr >= 4'(WEEK_DAYS)) begin
            n6_widx = 3'(s6_wr - 4'(WEEK_DAYS));
        end else begin
            n6_widx = s6_wr[2:0];
        end

        s6_hd = r5_th - r5_mh[12:0];
        s6_hr = s6_hd[8:0];
        if (s6_hr >= 9'(HOUR_DIV)) begin
            n6_hour = r5_h0 + 6'd1;
            n6_rt   = 8'(s6_hr - 9'(HOUR_DIV));
        end else begin
            n6_hour = r5_h0;
            n6_rt   = s6_hr[7:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctl.en[5]) begin
            r6_c   <= n6_c;
            r6_rc  <= n6_rc;
            r6_wd  <= n6_widx + 3'd1;
            r6_hr  <= n6_hour[4:0];
            r6_rem <= {n6_rt, r5_tlo};
        end
    end

    // ---- stage 7: year within cycle, minute estimate -----------------------
    logic [1:0]  n7_yc;
    logic [10:0] s7_doy;
    logic [5:0]  r7_c;
    logic [1:0]  r7_yc;
    logic [8:0]  r7_doy;
    t_wday       r7_wd;
    t_hour       r7_hr;
    logic [11:0] r7_rem;
    logic [38:0] r7_pm;

    always_comb begin
        n7_yc  = 2'(r6_rc >= year_base(2'd1)) + 2'(r6_rc >= year_base(2'd2))
               + 2'(r6_rc >= year_base(2'd3));
        s7_doy = r6_rc - year_base(n7_yc);
    end

    always_ff @(posedge i_clk) begin
        if (ctl.en[6]) begin
            r7_c   <= r6_c;
            r7_yc  <= n7_yc;
            r7_doy <= s7_doy[8:0];
            r7_wd  <= r6_wd;
            r7_hr  <= r6_hr;
            r7_rem <= r6_rem;
            r7_pm  <= 39'(r6_rem) * 39'(K_MIN);
        end
    end

    // ---- stage 8: month and day, minute back-multiply ----------------------
    logic [3:0]  n8_mp;
    logic [8:0]  s8_dd;
    t_month      n8_month;
    t_year       n8_year;
    t_year       r8_year;
    t_month      r8_month;
    t_mday       r8_day;
    t_wday       r8_wd;
    t_hour       r8_hr;
    logic [11:0] r8_rem;
    logic [6:0]  r8_mn0;
    logic [11:0] r8_mm;

    always_comb begin
        n8_mp = '0;
        for (int i = 1; i < 12; i++) begin
            if (r7_doy >= month_start(4'(i))) begin
                n8_mp = n8_mp + 4'd1;
            end
        end
        s8_dd = r7_doy - month_start(n8_mp);
        // January and February close the March-based year
        if (n8_mp >= FIRST_JAN_MP) begin
            n8_month = n8_mp - 4'd9;
            n8_year  = BASE_YEAR + {4'd0, r7_c, 2'd0} + 12'(r7_yc) + 12'd1;
        end else begin
            n8_month = n8_mp + 4'd3;
            n8_year  = BASE_YEAR + {4'd0, r7_c, 2'd0} + 12'(r7_yc);
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctl.en[7]) begin
            r8_year  <= n8_year;
            r8_month <= n8_month;
            r8_day   <= 5'(s8_dd + 9'd1);
            r8_wd    <= r7_wd;
            r8_hr    <= r7_hr;
            r8_rem   <= r7_rem;
            r8_mn0   <= r7_pm[38:32];
            r8_mm    <= 12'(13'(r7_pm[38:32]) * 13'(MIN_DIV));
        end
    end

    // ---- stage 9: correct minute, output register --------------------------
    logic [11:0] s9_d;
    logic [6:0]  s9_sr;
    logic [6:0]  n9_min;
    logic [6:0]  n9_sec;
    t_year       r9_year;
    t_month      r9_month;
    t_mday       r9_day;
    t_wday       r9_wd;
    t_hour       r9_hr;
    t_minsec     r9_min;
    t_minsec     r9_sec;

    always_comb begin
        s9_d  = r8_rem - r8_mm;
        s9_sr = s9_d[6:0];
        if (s9_sr >= 7'(MIN_DIV)) begin
            n9_min = r8_mn0 + 7'd1;
            n9_sec = s9_sr - 7'(MIN_DIV);
        end else begin
            n9_min = r8_mn0;
            n9_sec = s9_sr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctl.en[8]) begin
            r9_year  <= r8_year;
            r9_month <= r8_month;
            r9_day   <= r8_day;
            r9_wd    <= r8_wd;
            r9_hr    <= r8_hr;
            r9_min   <= n9_min[5:0];
            r9_sec   <= n9_sec[5:0];
        end
    end

    assign o_out.valid        = ctl.vld[NUM_STAGES-1];
    assign o_out.year         = r9_year;
    assign o_out.month        = r9_month;
    assign o_out.day_of_month = r9_day;
    assign o_out.hour         = r9_hr;
    assign o_out.minute       = r9_min;
    assign o_out.second       = r9_sec;
    assign o_out.weekday      = r9_wd;

endmodule

@@ tb/tb_epoch_seconds_to_calendar.sv @@
// ----------------------------------------------------------------------------
// tb_epoch_seconds_to_calendar
// Self-checking bench for the Unix-seconds to calendar converter. Drives
// timestamps over the valid/ready input channel with bursty traffic. Predicts
// each calendar record with a year-by-year, month-by-month walk. Compares
// every output transfer in order against the predicted records.
// ----------------------------------------------------------------------------
package tb_calendar_pkg;
    import e2c_pkg::*;

    typedef struct packed {
        t_year   year;
        t_month  month;
        t_mday   mday;
        t_hour   hour;
        t_minsec minute;
        t_minsec second;
        t_wday   wday;
    } t_cal_rec;

    class calendar_scoreboard;
        t_cal_rec    pending_q[$];
        int unsigned mismatches;
        int unsigned stamps_in;
        int unsigned records_out;

        function new();
            mismatches  = 0;
            stamps_in   = 0;
            records_out = 0;
        endfunction

        function bit leap_year(int unsigned yr);
            return (yr % 4 == 0) && ((yr % 100 != 0) || (yr % 400 == 0));
        endfunction

        function int unsigned month_length(int unsigned mon, bit leap);
            case (mon) inside
                2:             return leap ? 29 : 28;
                4, 6, 9, 11:   return 30;
                default:       return 31;
            endcase
        endfunction

        // Floor the day count so an exact midnight opens the new day.
        function t_cal_rec to_calendar(t_epoch secs);
            int unsigned days;
            int unsigned tod;
            int unsigned rest;
            int unsigned yr;
            int unsigned mon;
            int unsigned ylen;
            bit          leap;
            t_cal_rec    r;
            days = secs / 86400;
            tod  = secs % 86400;
            rest = days;
            yr   = 1970;
            ylen = leap_year(yr) ? 366 : 365;
            while (rest >= ylen) begin
                rest -= ylen;
                yr++;
                ylen = leap_year(yr) ? 366 : 365;
            end
            leap = leap_year(yr);
            mon  = 1;
            while (mon < 12 && rest >= month_length(mon, leap)) begin
                rest -= month_length(mon, leap);
                mon++;
            end
            r.year   = t_year'(yr);
            r.month  = t_month'(mon);
            r.mday   = t_mday'(rest + 1);
            r.hour   = t_hour'(tod / 3600);
            r.minute = t_minsec'((tod % 3600) / 60);
            r.second = t_minsec'(tod % 60);
            r.wday   = t_wday'((days + 3) % 7 + 1);
            return r;
        endfunction

        function void note_stamp(t_epoch secs);
            pending_q.push_back(to_calendar(secs));
            stamps_in++;
        endfunction

        task report(string msg);
            if (mismatches < 40)
                $display("ERROR result %0d: %s", records_out, msg);
            mismatches++;
        endtask

        task compare_field(string name, int unsigned got, int unsigned want);
            if (got != want)
                report($sformatf("%s got %0d, want %0d", name, got, want));
        endtask

        task check_record(t_cal_rec got);
            t_cal_rec want;
            if (pending_q.size() == 0) begin
                report($sformatf("unexpected record %0d-%0d-%0d", got.year, got.month,
                                 got.mday));
            end else begin
                want = pending_q.pop_front();
                compare_field("year",    got.year,   want.year);
                compare_field("month",   got.month,  want.month);
                compare_field("day",     got.mday,   want.mday);
                compare_field("hour",    got.hour,   want.hour);
                compare_field("minute",  got.minute, want.minute);
                compare_field("second",  got.second, want.second);
                compare_field("weekday", got.wday,   want.wday);
            end
            records_out++;
        endtask
    endclass
endpackage

module tb_epoch_seconds_to_calendar;
    timeunit 1ns;
    timeprecision 1ps;

    import e2c_pkg::*;
    import tb_calendar_pkg::*;

    localparam int unsigned RANDOM_STAMPS = 1700;
    localparam int unsigned HOLD_CYCLES   = 80;
    localparam int unsigned DRAIN_CYCLES  = 2 * NUM_STAGES + 4;
    localparam int unsigned CYCLE_LIMIT   = 200000;

    typedef enum logic [1:0] {RX_ALWAYS, RX_COIN, RX_SPARSE, RX_PERIODIC} t_rx_mode;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    bit   hold_req = 1'b0;
    int unsigned long_holds = 0;
    int unsigned cycle_count = 0;
    int unsigned corner_count = 0;

    calendar_scoreboard sb = new();

    e2c_in_if  in_ch();
    e2c_out_if out_ch();

    epoch_seconds_to_calendar dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d records still owed", cycle_count,
                     sb.pending_q.size());
            $display("epoch_seconds_to_calendar: mismatch");
            $finish;
        end
    end

    always @(posedge i_clk) begin : result_monitor
        t_cal_rec got;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got.year   = out_ch.year;
            got.month  = out_ch.month;
            got.mday   = out_ch.day_of_month;
            got.hour   = out_ch.hour;
            got.minute = out_ch.minute;
            got.second = out_ch.second;
            got.wday   = out_ch.weekday;
            sb.check_record(got);
        end
    end

    // Receiver: stretches of random length, each with its own ready pattern.
    initial begin : receiver
        t_rx_mode    mode;
        int unsigned span;
        int unsigned phase;
        out_ch.ready = 1'b0;
        span  = 0;
        phase = 0;
        mode  = RX_ALWAYS;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                out_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                long_holds++;
                hold_req = 1'b0;
            end
            if (span == 0) begin
                mode = t_rx_mode'($urandom_range(0, 3));
                span = $urandom_range(10, 90);
            end
            span--;
            phase++;
            case (mode)
                RX_ALWAYS:   out_ch.ready <= 1'b1;
                RX_COIN:     out_ch.ready <= 1'($urandom_range(0, 1));
                RX_SPARSE:   out_ch.ready <= ($urandom_range(0, 3) == 0);
                RX_PERIODIC: out_ch.ready <= ((phase % 7) < 4);
            endcase
        end
    end

    // Call at a falling edge; returns at the falling edge after the transfer.
    task automatic drive_stamp(input t_epoch secs);
        in_ch.valid         <= 1'b1;
        in_ch.epoch_seconds <= secs;
        do @(posedge i_clk); while (!(in_ch.valid && in_ch.ready));
        sb.note_stamp(secs);
        @(negedge i_clk);
    endtask

    task automatic idle_sender(input int unsigned cycles);
        in_ch.valid         <= 1'b0;
        in_ch.epoch_seconds <= $urandom;
        repeat (cycles) @(negedge i_clk);
    endtask

    task automatic wait_all_records();
        while (sb.pending_q.size() != 0) @(negedge i_clk);
    endtask

    function automatic t_epoch pick_stamp();
        longint unsigned v;
        int unsigned     offs;
        case ($urandom_range(0, 9)) inside
            0, 1, 2: v = $urandom;
            3, 4, 5: begin
                // land on or beside a day boundary
                case ($urandom_range(0, 4))
                    0:       offs = 0;
                    1:       offs = 1;
                    2:       offs = 86399;
                    3:       offs = 86398;
                    default: offs = $urandom_range(0, 59);
                endcase
                v = longint'($urandom_range(0, 49710)) * 86400 + offs;
                if (v > 64'hFFFF_FFFF)
                    v = 64'hFFFF_FFFF - $urandom_range(0, 3);
            end
            6, 7:    v = $urandom_range(32'hF000_0000, 32'hFFFF_FFFF);
            default: v = $urandom_range(0, 200000000);
        endcase
        return t_epoch'(v);
    endfunction

    initial begin : stimulus
        t_epoch corners[$];
        int unsigned sent;
        int unsigned burst;
        bit          paused_mid;
        in_ch.valid         = 1'b0;
        in_ch.epoch_seconds = '0;
        paused_mid          = 1'b0;
        corners = {
            32'd0,            // epoch start, a Thursday
            32'd1,
            32'd59, 32'd60, 32'd3599, 32'd3600,
            32'd86399,        // last second of day one
            32'd86400,        // exact midnight
            32'd31535999, 32'd31536000,   // end of 1970 into 1971
            32'd68169600,     // leap day 1972
            32'd94608000,     // last day of leap year 1972
            32'd946684800,    // 2000-01-01
            32'd951782400,    // leap day of a 400-year century
            32'd951868799, 32'd951868800,
            32'd4107456000,   // 2100-02-28: century year with no leap day
            32'd4107542399, 32'd4107542400,
            32'h7FFF_FFFF, 32'h8000_0000,
            32'hAAAA_AAAA, 32'h5555_5555,
            32'hFFFF_FFFE, 32'hFFFF_FFFF
        };

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Back-to-back corners first, then a pause until all are back.
        foreach (corners[k]) drive_stamp(corners[k]);
        corner_count = corners.size();
        idle_sender(0);
        wait_all_records();

        sent = 0;
        while (sent < RANDOM_STAMPS) begin
            // hold the receiver off once while the sender keeps offering
            if (sent >= 500 && long_holds == 0)
                hold_req = 1'b1;
            if (sent >= 1100 && !paused_mid) begin
                idle_sender(0);
                wait_all_records();
                paused_mid = 1'b1;
            end
            burst = $urandom_range(1, 30);
            while (burst != 0 && sent < RANDOM_STAMPS) begin
                drive_stamp(pick_stamp());
                sent++;
                burst--;
            end
            // roughly one burst in four runs straight into the next
            if ($urandom_range(0, 3) != 0)
                idle_sender($urandom_range(1, 8));
        end
        idle_sender(0);
        wait_all_records();
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        $display("%0d timestamps in (%0d calendar corners), %0d records checked",
                 sb.stamps_in, corner_count, sb.records_out);
        $display("%0d long output stalls with input backpressure, %0d mismatches",
                 long_holds, sb.mismatches);
        if (sb.mismatches == 0 && sb.pending_q.size() == 0) begin
            $display("epoch_seconds_to_calendar: match");
        end else begin
            $display("epoch_seconds_to_calendar: mismatch");
        end
        $finish;
    end
endmodule

@@ filelist.f @@
+incdir+hdl
hdl/e2c_pkg.sv
hdl/e2c_ifs.sv
hdl/e2c_pipe_ctrl.sv
hdl/epoch_seconds_to_calendar.sv
tb/tb_epoch_seconds_to_calendar.sv
